@@ src/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define BUR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a trigger is followed in the next cycle by a condition.
`define BUR_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

@@ src/bur_pkg.sv @@
// Shared types, constants and the tempering function of the bounded uniform random integer block.
`default_nettype none
package bur_pkg;
    localparam int WORD_W = 32;
    localparam int IDX_W = 10;
    localparam int MT_N = 624;
    localparam int MT_M = 397;
    localparam logic [WORD_W-1:0] SEED_RESET = 32'd5489;
    localparam logic [WORD_W-1:0] SEED_MULT = 32'd1812433253;
    localparam logic [WORD_W-1:0] MT_MAG = 32'h9908B0DF;
    localparam logic [WORD_W-1:0] SIGN_BIT = 32'h80000000;
    localparam logic [WORD_W-1:0] ALL_ONES = 32'hFFFFFFFF;

    typedef struct packed {
        logic              ready;
        logic              done;
        logic [WORD_W-1:0] word;
    } draw_rsp_t;

    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & 32'h9D2C5680);
        y = y ^ ((y << 15) & 32'hEFC60000);
        y = y ^ (y >> 18);
        return y;
    endfunction
endpackage
`default_nettype wire

@@ src/bur_ram.sv @@
// Generic RAM: one write port, two registered read ports.
`default_nettype none
module bur_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr_a,
    input  wire logic [AW-1:0]    raddr_b,
    output logic      [WIDTH-1:0] rdata_a,
    output logic      [WIDTH-1:0] rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule
`default_nettype wire

@@ src/bur_rem.sv @@
// Iterative 32-bit remainder unit, one quotient bit per cycle.
`default_nettype none
module bur_rem (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [bur_pkg::WORD_W-1:0] dividend,
    input  wire logic [bur_pkg::WORD_W-1:0] divisor,
    output logic                           done,
    output logic      [bur_pkg::WORD_W-1:0] rem
);
    localparam int CW = $clog2(bur_pkg::WORD_W + 1);

    logic [bur_pkg::WORD_W-1:0] rem_reg, rem_next;
    logic [bur_pkg::WORD_W-1:0] quo_reg, quo_next;
    logic [bur_pkg::WORD_W-1:0] div_reg, div_next;
    logic [CW-1:0]              cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [bur_pkg::WORD_W:0]   trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[bur_pkg::WORD_W-1]};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // restore when the trial subtraction would go negative
            if (trial >= {1'b0, div_reg})
            begin
                trial = trial - {1'b0, div_reg};
            end
            rem_next = trial[bur_pkg::WORD_W-1:0];
            quo_next = quo_reg << 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(bur_pkg::WORD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;
endmodule
`default_nettype wire

@@ src/bur_twister.sv @@
// MT19937 word source: seeding, regeneration and draws over one word RAM.
`default_nettype none
module bur_twister (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       seed_we,
    input  wire logic [bur_pkg::WORD_W-1:0] seed_wdata,
    input  wire logic                       draw_req,
    output bur_pkg::draw_rsp_t              rsp
);
    localparam logic [3:0] T_SEED_W0  = 4'd0;
    localparam logic [3:0] T_SEED_MUL = 4'd1;
    localparam logic [3:0] T_SEED_ADD = 4'd2;
    localparam logic [3:0] T_IDLE     = 4'd3;
    localparam logic [3:0] T_PRE      = 4'd4;
    localparam logic [3:0] T_LOAD     = 4'd5;
    localparam logic [3:0] T_RG_RD    = 4'd6;
    localparam logic [3:0] T_RG_WR    = 4'd7;
    localparam logic [3:0] T_DR_RD    = 4'd8;
    localparam logic [3:0] T_DR_OUT   = 4'd9;

    localparam int IW = bur_pkg::IDX_W;
    localparam logic [IW-1:0] LAST = IW'(bur_pkg::MT_N - 1);

    logic [3:0]                 state_reg, state_next;
    logic [IW-1:0]              i_reg, i_next;
    logic [IW-1:0]              idx_reg, idx_next;
    logic [bur_pkg::WORD_W-1:0] seed_reg, seed_next;
    logic [bur_pkg::WORD_W-1:0] p_reg, p_next;
    logic [bur_pkg::WORD_W-1:0] prod_reg, prod_next;
    logic [bur_pkg::WORD_W-1:0] cur_reg, cur_next;

    logic                       we;
    logic [IW-1:0]              waddr, raddr_a, raddr_b;
    logic [bur_pkg::WORD_W-1:0] wdata, rdata_a, rdata_b, y, v;

    bur_ram #(.WIDTH(bur_pkg::WORD_W), .DEPTH(bur_pkg::MT_N)) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        idx_next   = idx_reg;
        seed_next  = seed_reg;
        p_next     = p_reg;
        prod_next  = prod_reg;
        cur_next   = cur_reg;
        we         = 1'b0;
        waddr      = i_reg;
        wdata      = prod_reg + bur_pkg::WORD_W'(i_reg);
        raddr_a    = idx_reg;
        raddr_b    = (i_reg < IW'(bur_pkg::MT_N - bur_pkg::MT_M))
                   ? i_reg + IW'(bur_pkg::MT_M) : i_reg - IW'(bur_pkg::MT_N - bur_pkg::MT_M);
        y          = {cur_reg[bur_pkg::WORD_W-1], rdata_a[bur_pkg::WORD_W-2:0]};
        v          = rdata_b ^ (y >> 1) ^ (y[0] ? bur_pkg::MT_MAG : '0);
        rsp.ready  = (state_reg == T_IDLE);
        rsp.done   = 1'b0;
        rsp.word   = bur_pkg::temper(rdata_a);
        case (state_reg)
            T_SEED_W0:
            begin
                we         = 1'b1;
                waddr      = '0;
                wdata      = seed_reg;
                p_next     = seed_reg;
                i_next     = IW'(1);
                state_next = T_SEED_MUL;
            end
            T_SEED_MUL:
            begin
                prod_next  = bur_pkg::SEED_MULT * (p_reg ^ (p_reg >> 30));
                state_next = T_SEED_ADD;
            end
            T_SEED_ADD:
            begin
                we     = 1'b1;
                p_next = wdata;
                if (i_reg == LAST)
                begin
                    idx_next   = IW'(bur_pkg::MT_N);
                    state_next = T_IDLE;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = T_SEED_MUL;
                end
            end
            T_IDLE:
            begin
                if (draw_req)
                begin
                    // index past the end: regenerate the whole store first
                    if (idx_reg >= IW'(bur_pkg::MT_N))
                    begin
                        i_next     = '0;
                        state_next = T_PRE;
                    end
                    else
                    begin
                        state_next = T_DR_RD;
                    end
                end
            end
            T_PRE:
            begin
                raddr_a    = '0;
                state_next = T_LOAD;
            end
            T_LOAD:
            begin
                cur_next   = rdata_a;
                state_next = T_RG_RD;
            end
            T_RG_RD:
            begin
                raddr_a    = (i_reg == LAST) ? '0 : i_reg + 1'b1;
                state_next = T_RG_WR;
            end
            T_RG_WR:
            begin
                we       = 1'b1;
                wdata    = v;
                cur_next = rdata_a;
                if (i_reg == LAST)
                begin
                    idx_next   = '0;
                    state_next = T_DR_RD;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = T_RG_RD;
                end
            end
            T_DR_RD:
            begin
                idx_next   = idx_reg + 1'b1;
                state_next = T_DR_OUT;
            end
            T_DR_OUT:
            begin
                rsp.done   = 1'b1;
                state_next = T_IDLE;
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
        // a seed write restarts the seeding pass
        if (seed_we)
        begin
            seed_next  = seed_wdata;
            state_next = T_SEED_W0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_SEED_W0;
            seed_reg  <= bur_pkg::SEED_RESET;
            idx_reg   <= IW'(bur_pkg::MT_N);
            i_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            seed_reg  <= seed_next;
            idx_reg   <= idx_next;
            i_reg     <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg    <= p_next;
        prod_reg <= prod_next;
        cur_reg  <= cur_next;
    end
endmodule
`default_nettype wire

@@ src/bounded_uniform_random_integer.sv @@
// Top level: request control, rejection loop and output register.
//
//  channel  | direction | beat contents
//  s_axis   | in        | tdata {high_bound, low_bound}, tuser unsigned_mode
//  m_axis   | out       | tdata value, tuser tries_exhausted
//  seed     | in        | seed_we / seed_wdata, one write per cycle
//
// A non power-of-two span runs these steps: classify, the limit remainder, a word
// draw and check, the final remainder and the hand-off; each rejected word adds
// another draw and check, and the try-limit fold another remainder. Every 624th
// draw first regenerates the word RAM one word at a time, through its two read
// ports and one write port. Reset and each seed write start a seeding pass that
// holds s_axis_tready low. A stalled result waits in the output register.
`default_nettype none
module bounded_uniform_random_integer #(
    parameter int MAX_TRIES = 20
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        seed_we,
    input  wire logic [31:0] seed_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // [31:0] low_bound, [63:32] high_bound
    input  wire logic        s_axis_tuser,  // [0] unsigned_mode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,  // [31:0] value
    output logic             m_axis_tuser   // [0] tries_exhausted
);
    localparam int CW = $clog2(MAX_TRIES + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLASS = 3'd1;
    localparam logic [2:0] S_LIM   = 3'd2;
    localparam logic [2:0] S_DRAW  = 3'd3;
    localparam logic [2:0] S_WAIT  = 3'd4;
    localparam logic [2:0] S_CHECK = 3'd5;
    localparam logic [2:0] S_MOD   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    localparam logic [1:0] M_FULL = 2'd0;
    localparam logic [1:0] M_POW2 = 2'd1;
    localparam logic [1:0] M_REJ  = 2'd2;

    logic [2:0]  state_reg, state_next;
    logic [1:0]  mode_reg, mode_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic        exh_reg, exh_next;
    logic        fb_reg, fb_next;
    logic [31:0] ls_reg, ls_next, rs_reg, rs_next, flip_reg, flip_next;
    logic [31:0] span_reg, span_next, lim_reg, lim_next;
    logic [31:0] r_reg, r_next, res_reg, res_next;
    logic        ov_reg, ov_next;
    logic [31:0] od_reg, od_next;
    logic        ou_reg, ou_next;

    logic        draw_req;
    bur_pkg::draw_rsp_t rsp;
    logic        rem_start, rem_done;
    logic [31:0] rem_dividend, rem_divisor, rem_val, span_c;

    bur_twister u_twister (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed_we    (seed_we),
        .seed_wdata (seed_wdata),
        .draw_req   (draw_req),
        .rsp        (rsp)
    );

    bur_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (rem_dividend),
        .divisor  (rem_divisor),
        .done     (rem_done),
        .rem      (rem_val)
    );

    assign s_axis_tready = (state_reg == S_IDLE) && rsp.ready;

    always_comb
    begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        cnt_next     = cnt_reg;
        exh_next     = exh_reg;
        fb_next      = fb_reg;
        ls_next      = ls_reg;
        rs_next      = rs_reg;
        flip_next    = flip_reg;
        span_next    = span_reg;
        lim_next     = lim_reg;
        r_next       = r_reg;
        res_next     = res_reg;
        od_next      = od_reg;
        ou_next      = ou_reg;
        ov_next      = ov_reg && !m_axis_tready;
        draw_req     = 1'b0;
        rem_start    = 1'b0;
        rem_dividend = r_reg;
        rem_divisor  = span_reg;
        span_c       = rs_reg - ls_reg + 32'd1;
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    flip_next  = s_axis_tuser ? bur_pkg::SIGN_BIT : '0;
                    ls_next    = s_axis_tdata[31:0] ^ flip_next;
                    rs_next    = s_axis_tdata[63:32] ^ flip_next;
                    exh_next   = 1'b0;
                    fb_next    = 1'b0;
                    cnt_next   = '0;
                    state_next = S_CLASS;
                end
            end
            S_CLASS:
            begin
                span_next = span_c;
                if ($signed(ls_reg) >= $signed(rs_reg))
                begin
                    res_next   = ls_reg;
                    state_next = S_DONE;
                end
                else if (ls_reg == bur_pkg::SIGN_BIT && rs_reg == ~bur_pkg::SIGN_BIT)
                begin
                    mode_next  = M_FULL;
                    state_next = S_DRAW;
                end
                else if ((span_c & (span_c - 32'd1)) == '0)
                begin
                    mode_next  = M_POW2;
                    state_next = S_DRAW;
                end
                else
                begin
                    mode_next    = M_REJ;
                    rem_start    = 1'b1;
                    rem_dividend = bur_pkg::ALL_ONES;
                    rem_divisor  = span_c;
                    state_next   = S_LIM;
                end
            end
            S_LIM:
            begin
                if (rem_done)
                begin
                    lim_next   = bur_pkg::ALL_ONES - rem_val;
                    state_next = S_DRAW;
                end
            end
            S_DRAW:
            begin
                draw_req   = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (rsp.done)
                begin
                    case (mode_reg)
                        M_FULL:
                        begin
                            res_next   = rsp.word;
                            state_next = S_DONE;
                        end
                        M_POW2:
                        begin
                            res_next   = ls_reg + (rsp.word & (span_reg - 32'd1));
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            r_next     = rsp.word;
                            state_next = S_CHECK;
                        end
                    endcase
                end
            end
            S_CHECK:
            begin
                if (r_reg >= lim_reg)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_next >= CW'(MAX_TRIES))
                    begin
                        // out of tries: fold the last word below the limit
                        exh_next    = 1'b1;
                        fb_next     = 1'b1;
                        rem_start   = 1'b1;
                        rem_divisor = lim_reg;
                        state_next  = S_MOD;
                    end
                    else
                    begin
                        state_next = S_DRAW;
                    end
                end
                else
                begin
                    fb_next    = 1'b0;
                    rem_start  = 1'b1;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (rem_done)
                begin
                    if (fb_reg)
                    begin
                        r_next     = rem_val;
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        res_next   = ls_reg + rem_val;
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (!ov_reg || m_axis_tready)
                begin
                    ov_next    = 1'b1;
                    od_next    = res_reg ^ flip_reg;
                    ou_next    = exh_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            cnt_reg   <= '0;
            fb_reg    <= 1'b0;
            mode_reg  <= M_FULL;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            cnt_reg   <= cnt_next;
            fb_reg    <= fb_next;
            mode_reg  <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        exh_reg  <= exh_next;
        ls_reg   <= ls_next;
        rs_reg   <= rs_next;
        flip_reg <= flip_next;
        span_reg <= span_next;
        lim_reg  <= lim_next;
        r_reg    <= r_next;
        res_reg  <= res_next;
        od_reg   <= od_next;
        ou_reg   <= ou_next;
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tuser  = ou_reg;
endmodule
`default_nettype wire

@@ src/bur_checker.sv @@
// Port-level checks of the top level, bound to it.
`default_nettype none
`include "assert_macros.svh"
module bur_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        seed_we,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);
    `BUR_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result beat changed while stalled")
    `BUR_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second request taken while one is in work")
    `BUR_ASSERT_NEXT(a_seed_blocks, clk, rst_n, seed_we, !s_axis_tready, "request taken during reseeding")
endmodule

bind bounded_uniform_random_integer bur_checker u_bur_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .seed_we       (seed_we),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
